>>> hdl/ecnq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking packet queue package
// Shared widths, codes and the result record of the egress packet queue.
// ----------------------------------------------------------------------------
package ecnq_pkg;

    // Descriptor store depth per class; kept a power of two so pointers wrap.
    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam int TAG_W   = 16;
    localparam int SIZE_W  = 14;
    localparam int BYTES_W = 24;
    localparam int DROP_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Operation of an input transfer.
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_SENT     = 2'd2;
    localparam logic [1:0] ST_NOTHING  = 2'd3;

    // Service class codes.
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_LOW  = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_MAX_BYTES = 2'd0;
    localparam logic [1:0] REG_MARK_THR  = 2'd1;
    localparam logic [1:0] REG_PRIO_EN   = 2'd2;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 24'd1048576;
    localparam logic [BYTES_W-1:0] MARK_THR_RST  = 24'd65536;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] bytes;
    } desc_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   tag;
        logic [SIZE_W-1:0]  bytes;
        logic               ecn_ce;
        logic [1:0]         serving_class;
        logic [BYTES_W-1:0] total_bytes;
        logic [BYTES_W-1:0] peak_bytes;
        logic [DROP_W-1:0]  drop_count;
    } result_t;

endpackage

>>> hdl/ecn_marking_packet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECN marking packet queue
// Egress queue of packet descriptors in two class memories with byte limit
// drops, strict priority service and threshold based CE marking.
// ----------------------------------------------------------------------------
//  Channel   Handshake                        Payload
//  input     in_valid / in_stall              func, pkt_tag, pkt_bytes, high_class
//  output    out_valid / out_stall            status, out_tag, out_bytes, ecn_ce,
//                                             serving_class, total_bytes, peak_bytes,
//                                             drop_count
//  config    psel/penable/pwrite/pready APB   paddr, pwdata, prdata
//
//  An enqueue, or a completion that sends nothing, is worked out in the cycle
//  of its transfer and registered, and the next input can be taken at once:
//  one item per cycle while the skid register is not full. A completion
//  that sends a packet holds the input in the pop state while the head
//  descriptor is read from its class memory through a registered read port;
//  its result is then worked out from that descriptor and registered.
//  Reset clears all counters and pointers at once; the memories need no pass.
//  A result waiting on out_stall sits in the output register while a second
//  one may fill a skid register; input is stalled while that is full and
//  during the memory read cycle of a sending completion.
// ----------------------------------------------------------------------------
module ecn_marking_packet_queue
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [ecnq_pkg::TAG_W-1:0]     pkt_tag,
    input  logic [ecnq_pkg::SIZE_W-1:0]    pkt_bytes,
    input  logic                           high_class,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [ecnq_pkg::TAG_W-1:0]     out_tag,
    output logic [ecnq_pkg::SIZE_W-1:0]    out_bytes,
    output logic                           ecn_ce,
    output logic [1:0]                     serving_class,
    output logic [ecnq_pkg::BYTES_W-1:0]   total_bytes,
    output logic [ecnq_pkg::BYTES_W-1:0]   peak_bytes,
    output logic [ecnq_pkg::DROP_W-1:0]    drop_count,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecnq_pkg::ADDR_W-1:0]    paddr,
    input  logic [ecnq_pkg::DATA_W-1:0]    pwdata,
    output logic [ecnq_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    import ecnq_pkg::*;

    typedef enum logic {ST_IDLE, ST_POP} state_t;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // Class memories.
    desc_t lo_mem [QUEUE_DEPTH];
    desc_t hi_mem [QUEUE_DEPTH];
    desc_t lo_rd_reg;
    desc_t hi_rd_reg;

    // Configuration registers.
    logic [BYTES_W-1:0] max_bytes_reg;
    logic [BYTES_W-1:0] mark_thr_reg;
    logic               prio_en_reg;

    // Queue state.
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   lo_head_reg, lo_head_next, hi_head_reg, hi_head_next;
    logic [CNT_W-1:0]   lo_count_reg, lo_count_next, hi_count_reg, hi_count_next;
    logic [BYTES_W-1:0] lo_bytes_reg, lo_bytes_next, hi_bytes_reg, hi_bytes_next;
    logic [1:0]         service_reg, service_next;
    logic [1:0]         pop_class_reg, pop_class_next;
    logic [BYTES_W-1:0] peak_reg, peak_next;
    logic [DROP_W-1:0]  drops_reg, drops_next;

    // Output register and skid stage.
    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg, res_valid;

    // Memory access controls.
    logic             lo_wr, hi_wr, lo_rd, hi_rd;
    logic [PTR_W-1:0] wr_addr;
    desc_t            wr_data;

    logic in_fire, out_take, cfg_wr;

    assign in_stall = (state_reg != ST_IDLE) || skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // Configuration register reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAX_BYTES: prdata = DATA_W'(max_bytes_reg);
            REG_MARK_THR:  prdata = DATA_W'(mark_thr_reg);
            REG_PRIO_EN:   prdata = DATA_W'(prio_en_reg);
            default:       prdata = '0;
        endcase
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RST;
            mark_thr_reg  <= MARK_THR_RST;
            prio_en_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAX_BYTES: max_bytes_reg <= pwdata[BYTES_W-1:0];
                REG_MARK_THR:  mark_thr_reg  <= pwdata[BYTES_W-1:0];
                REG_PRIO_EN:   prio_en_reg   <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Queue control: enqueue, completion and the memory read-modify cycle.
    always_comb
    begin
        logic [BYTES_W-1:0] tot;
        logic [BYTES_W-1:0] new_tot;
        logic [BYTES_W:0]   sum;
        logic               sel_hi;
        logic               full;
        desc_t              d;

        tot     = lo_bytes_reg + hi_bytes_reg;
        sum     = {1'b0, tot} + (BYTES_W + 1)'(pkt_bytes);
        sel_hi  = prio_en_reg && high_class;
        full    = sel_hi ? (hi_count_reg == DEPTH_CNT) : (lo_count_reg == DEPTH_CNT);
        d       = (pop_class_reg == CLS_HIGH) ? hi_rd_reg : lo_rd_reg;
        new_tot = '0;

        state_next     = state_reg;
        lo_head_next   = lo_head_reg;
        hi_head_next   = hi_head_reg;
        lo_count_next  = lo_count_reg;
        hi_count_next  = hi_count_reg;
        lo_bytes_next  = lo_bytes_reg;
        hi_bytes_next  = hi_bytes_reg;
        service_next   = service_reg;
        pop_class_next = pop_class_reg;
        peak_next      = peak_reg;
        drops_next     = drops_reg;

        lo_wr   = 1'b0;
        hi_wr   = 1'b0;
        lo_rd   = 1'b0;
        hi_rd   = 1'b0;
        wr_data = '{tag: pkt_tag, bytes: pkt_bytes};
        wr_addr = sel_hi ? hi_head_reg + hi_count_reg[PTR_W-1:0]
                         : lo_head_reg + lo_count_reg[PTR_W-1:0];

        res       = '0;
        res_valid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FUNC_ENQ)
                    begin
                        res_valid = 1'b1;
                        if (sum > {1'b0, max_bytes_reg} || full)
                        begin
                            res.status = ST_DROPPED;
                            if (drops_reg != '1)
                                drops_next = drops_reg + 1'b1;
                        end
                        else
                        begin
                            res.status = ST_ACCEPTED;
                            if (sel_hi)
                            begin
                                hi_wr         = 1'b1;
                                hi_count_next = hi_count_reg + 1'b1;
                                hi_bytes_next = hi_bytes_reg + BYTES_W'(pkt_bytes);
                            end
                            else
                            begin
                                lo_wr         = 1'b1;
                                lo_count_next = lo_count_reg + 1'b1;
                                lo_bytes_next = lo_bytes_reg + BYTES_W'(pkt_bytes);
                            end
                            new_tot = tot + BYTES_W'(pkt_bytes);
                            if (new_tot > peak_reg)
                                peak_next = new_tot;
                            if (service_reg == CLS_NONE)
                            begin
                                priority if (hi_count_next != '0) service_next = CLS_HIGH;
                                else if (lo_count_next != '0)     service_next = CLS_LOW;
                                else                              service_next = CLS_NONE;
                            end
                        end
                    end
                    else if (service_reg == CLS_NONE)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_NOTHING;
                    end
                    else if ((service_reg == CLS_HIGH && hi_count_reg == '0) ||
                             (service_reg != CLS_HIGH && lo_count_reg == '0))
                    begin
                        // Class in service is empty: restart service from scratch.
                        res_valid  = 1'b1;
                        res.status = ST_NOTHING;
                        priority if (hi_count_reg != '0) service_next = CLS_HIGH;
                        else if (lo_count_reg != '0)     service_next = CLS_LOW;
                        else                             service_next = CLS_NONE;
                    end
                    else
                    begin
                        // Read the head descriptor; it is used in the next cycle.
                        hi_rd          = (service_reg == CLS_HIGH);
                        lo_rd          = (service_reg != CLS_HIGH);
                        pop_class_next = service_reg;
                        state_next     = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                res_valid  = 1'b1;
                res.status = ST_SENT;
                res.tag    = d.tag;
                res.bytes  = d.bytes;
                res.ecn_ce = (tot > mark_thr_reg);
                if (pop_class_reg == CLS_HIGH)
                begin
                    hi_head_next  = hi_head_reg + 1'b1;
                    hi_count_next = hi_count_reg - 1'b1;
                    hi_bytes_next = hi_bytes_reg - BYTES_W'(d.bytes);
                end
                else
                begin
                    lo_head_next  = lo_head_reg + 1'b1;
                    lo_count_next = lo_count_reg - 1'b1;
                    lo_bytes_next = lo_bytes_reg - BYTES_W'(d.bytes);
                end
                priority if (hi_count_next != '0) service_next = CLS_HIGH;
                else if (lo_count_next != '0)     service_next = CLS_LOW;
                else                              service_next = CLS_NONE;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Status fields reflect the state after this step.
        res.serving_class = service_next;
        res.total_bytes   = lo_bytes_next + hi_bytes_next;
        res.peak_bytes    = peak_next;
        res.drop_count    = drops_next;
    end

    // Class memories: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (lo_wr)
            lo_mem[wr_addr] <= wr_data;
        if (hi_wr)
            hi_mem[wr_addr] <= wr_data;
        if (lo_rd)
            lo_rd_reg <= lo_mem[lo_head_reg];
        if (hi_rd)
            hi_rd_reg <= hi_mem[hi_head_reg];
    end

    // State, queue counters and the output register with its skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lo_head_reg    <= '0;
            hi_head_reg    <= '0;
            lo_count_reg   <= '0;
            hi_count_reg   <= '0;
            lo_bytes_reg   <= '0;
            hi_bytes_reg   <= '0;
            service_reg    <= CLS_NONE;
            pop_class_reg  <= CLS_NONE;
            peak_reg       <= '0;
            drops_reg      <= '0;
            out_reg        <= '0;
            skid_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_head_reg   <= lo_head_next;
            hi_head_reg   <= hi_head_next;
            lo_count_reg  <= lo_count_next;
            hi_count_reg  <= hi_count_next;
            lo_bytes_reg  <= lo_bytes_next;
            hi_bytes_reg  <= hi_bytes_next;
            service_reg   <= service_next;
            pop_class_reg <= pop_class_next;
            peak_reg      <= peak_next;
            drops_reg     <= drops_next;

            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_reg       <= skid_reg;
                    out_valid_reg <= 1'b1;
                    if (res_valid)
                        skid_reg <= res;
                    else
                        skid_valid_reg <= 1'b0;
                end
                else if (res_valid)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output ports.
    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign out_tag       = out_reg.tag;
    assign out_bytes     = out_reg.bytes;
    assign ecn_ce        = out_reg.ecn_ce;
    assign serving_class = out_reg.serving_class;
    assign total_bytes   = out_reg.total_bytes;
    assign peak_bytes    = out_reg.peak_bytes;
    assign drop_count    = out_reg.drop_count;

endmodule

>>> test/tb_ecn_marking_packet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ECN marking packet queue
// Drives enqueue and completion transfers, predicts every result from its own
// copy of the class queues, byte totals and registers, and compares each
// result transfer field by field. A directed pass covers the edge cases and
// is followed by random traffic under several register settings and idling
// patterns.
// ----------------------------------------------------------------------------
module tb_ecn_marking_packet_queue;

    import ecnq_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam logic [BYTES_W-1:0] BYTES_ALL = '1;

    logic                clk;
    logic                rst_n      = 1'b0;

    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                func       = FUNC_ENQ;
    logic [TAG_W-1:0]    pkt_tag    = '0;
    logic [SIZE_W-1:0]   pkt_bytes  = '0;
    logic                high_class = 1'b0;

    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [1:0]          status;
    logic [TAG_W-1:0]    out_tag;
    logic [SIZE_W-1:0]   out_bytes;
    logic                ecn_ce;
    logic [1:0]          serving_class;
    logic [BYTES_W-1:0]  total_bytes;
    logic [BYTES_W-1:0]  peak_bytes;
    logic [DROP_W-1:0]   drop_count;

    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predicted queue state: index 0 is the low class, index 1 the high class.
    desc_t               class_mem   [2][QUEUE_DEPTH];
    int unsigned         class_head  [2];
    int unsigned         class_cnt   [2];
    bit [BYTES_W-1:0]    class_bytes [2];
    bit [1:0]            svc_class   = CLS_NONE;
    bit [BYTES_W-1:0]    peak_seen   = '0;
    bit [DROP_W-1:0]     drop_total  = '0;

    // Predicted register contents.
    bit [BYTES_W-1:0]    cap_bytes    = MAX_BYTES_RST;
    bit [BYTES_W-1:0]    ce_threshold = MARK_THR_RST;
    bit                  prio_on      = 1'b0;

    result_t             pending_results [$];
    int unsigned         mismatches  = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         idle_pct    = 0;
    int unsigned         stall_pct   = 0;
    int unsigned         idle_phase  = 0;

    ecn_marking_packet_queue u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .pkt_tag       (pkt_tag),
        .pkt_bytes     (pkt_bytes),
        .high_class    (high_class),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_tag       (out_tag),
        .out_bytes     (out_bytes),
        .ecn_ce        (ecn_ce),
        .serving_class (serving_class),
        .total_bytes   (total_bytes),
        .peak_bytes    (peak_bytes),
        .drop_count    (drop_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Service starts on the high class whenever it holds a packet.
    function automatic logic [1:0] pick_class();
        if (class_cnt[1] != 0)
            return CLS_HIGH;
        else if (class_cnt[0] != 0)
            return CLS_LOW;
        return CLS_NONE;
    endfunction

    // Advances the predicted queue by one input transfer and returns its result.
    function automatic result_t queue_step(input logic f, input logic [TAG_W-1:0] tag,
                                           input logic [SIZE_W-1:0] sz, input logic hi);
        result_t           r;
        desc_t             d;
        int                q;
        int unsigned       pos;
        logic [BYTES_W:0]  need;
        logic [BYTES_W-1:0] tot;
        r   = '0;
        tot = class_bytes[0] + class_bytes[1];
        if (f == FUNC_ENQ)
        begin
            q    = (prio_on && hi) ? 1 : 0;
            need = tot + sz;
            if (need > {1'b0, cap_bytes} || class_cnt[q] >= QUEUE_DEPTH)
            begin
                r.status = ST_DROPPED;
                if (drop_total != '1)
                    drop_total++;
            end
            else
            begin
                r.status = ST_ACCEPTED;
                pos = (class_head[q] + class_cnt[q]) % QUEUE_DEPTH;
                class_mem[q][pos].tag   = tag;
                class_mem[q][pos].bytes = sz;
                class_cnt[q]++;
                class_bytes[q] = class_bytes[q] + sz;
                tot = class_bytes[0] + class_bytes[1];
                if (tot > peak_seen)
                    peak_seen = tot;
                if (svc_class == CLS_NONE)
                    svc_class = pick_class();
            end
        end
        else if (svc_class == CLS_NONE)
        begin
            r.status = ST_NOTHING;
        end
        else
        begin
            q = (svc_class == CLS_HIGH) ? 1 : 0;
            if (class_cnt[q] == 0)
            begin
                r.status = ST_NOTHING;
            end
            else
            begin
                // The mark is decided on the total before the departure is taken off.
                d = class_mem[q][class_head[q]];
                class_head[q]  = (class_head[q] + 1) % QUEUE_DEPTH;
                class_cnt[q]--;
                class_bytes[q] = class_bytes[q] - d.bytes;
                r.status = ST_SENT;
                r.tag    = d.tag;
                r.bytes  = d.bytes;
                r.ecn_ce = (tot > ce_threshold);
            end
            svc_class = pick_class();
        end
        r.serving_class = svc_class;
        r.total_bytes   = class_bytes[0] + class_bytes[1];
        r.peak_bytes    = peak_seen;
        r.drop_count    = drop_total;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Sends one input transfer, with a random gap first, and records its prediction.
    task automatic send_item(input logic f, input logic [TAG_W-1:0] tag,
                             input logic [SIZE_W-1:0] sz, input logic hi);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        pkt_tag    <= tag;
        pkt_bytes  <= sz;
        high_class <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(queue_step(f, tag, sz, hi));
    endtask

    // Stops sending and waits until every predicted result has been transferred.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register once the queue is idle, then reads it back.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] want;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_MAX_BYTES: cap_bytes    = val[BYTES_W-1:0];
            REG_MARK_THR:  ce_threshold = val[BYTES_W-1:0];
            default:       prio_on      = val[0];
        endcase
        // Read back through a setup and an access cycle.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_MAX_BYTES: want = DATA_W'(cap_bytes);
            REG_MARK_THR:  want = DATA_W'(ce_threshold);
            default:       want = DATA_W'(prio_on);
        endcase
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic under one register setting, rotating the idling pattern.
    task automatic run_traffic(input logic [BYTES_W-1:0] cap, input logic [BYTES_W-1:0] thr,
                               input logic prio, input int unsigned enq_pct,
                               input int unsigned count);
        logic [SIZE_W-1:0] sz;
        logic              f;
        write_reg(REG_MAX_BYTES, DATA_W'(cap));
        write_reg(REG_MARK_THR, DATA_W'(thr));
        write_reg(REG_PRIO_EN, DATA_W'(prio));
        for (int k = 0; k < count; k++)
        begin
            if (k % 75 == 0)
            begin
                case (idle_phase % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 57; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 57; end
                    default: begin idle_pct = 33; stall_pct = 33; end
                endcase
                idle_phase++;
            end
            // Sizes lean towards the extremes and towards small packets.
            case ($urandom_range(9))
                0:       sz = '0;
                1:       sz = '1;
                2, 3:    sz = SIZE_W'($urandom_range(64));
                default: sz = SIZE_W'($urandom_range(16383));
            endcase
            f = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            send_item(f, TAG_W'($urandom), sz, 1'($urandom_range(1)));
        end
    endtask

    // Completion on an empty queue and the extremes of every input field.
    task automatic test_field_extremes();
        send_item(FUNC_DEQ, '1, '1, 1'b1);
        send_item(FUNC_ENQ, '0, '0, 1'b0);
        send_item(FUNC_ENQ, '1, '1, 1'b1);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        send_item(FUNC_DEQ, '1, '1, 1'b1);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
    endtask

    // CE marking just above the threshold and not at equality.
    task automatic test_ce_marking();
        write_reg(REG_MARK_THR, '0);
        send_item(FUNC_ENQ, 16'h0001, 14'd1, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        write_reg(REG_MARK_THR, 32'd100);
        send_item(FUNC_ENQ, 16'h0002, 14'd100, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
    endtask

    // Capacity equality, byte limit drops and a limit lowered under a full queue.
    task automatic test_byte_capacity();
        write_reg(REG_MAX_BYTES, 32'd200);
        send_item(FUNC_ENQ, 16'h0010, 14'd100, 1'b0);
        send_item(FUNC_ENQ, 16'h0011, 14'd100, 1'b0);
        send_item(FUNC_ENQ, 16'h0012, 14'd1, 1'b0);
        write_reg(REG_MAX_BYTES, '0);
        send_item(FUNC_ENQ, 16'h0013, 14'd0, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        send_item(FUNC_ENQ, 16'h0014, 14'd0, 1'b0);
        send_item(FUNC_ENQ, 16'h0015, 14'd1, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        write_reg(REG_MAX_BYTES, DATA_W'(BYTES_ALL));
    endtask

    // No preemption of the class in service, and high entries kept after disable.
    task automatic test_priority_order();
        write_reg(REG_PRIO_EN, 32'd1);
        send_item(FUNC_ENQ, 16'h0100, 14'd10, 1'b0);
        send_item(FUNC_ENQ, 16'h0200, 14'd20, 1'b1);
        write_reg(REG_PRIO_EN, '0);
        send_item(FUNC_ENQ, 16'h0101, 14'd30, 1'b1);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
        send_item(FUNC_DEQ, '0, '0, 1'b0);
    endtask

    // Enqueue heavy traffic until the low class store fills and drops arrivals.
    task automatic test_fifo_full();
        run_traffic(BYTES_ALL, '0, 1'b0, 95, 330);
    endtask

    // Both classes in use with strict priority and a mid range threshold.
    task automatic test_priority_mix();
        run_traffic(BYTES_ALL, BYTES_W'($urandom_range(2000000, 200000)), 1'b1, 90, 260);
    endtask

    // Completion heavy traffic that empties both classes.
    task automatic test_drain();
        run_traffic(BYTES_ALL, BYTES_ALL, 1'b1, 10, 400);
    endtask

    // Traffic held close to a small byte limit.
    task automatic test_byte_limit();
        run_traffic(24'd60000, 24'd30000, 1'b1, 55, 300);
    endtask

    // Zero capacity: only empty packets on an empty queue get in.
    task automatic test_zero_capacity();
        run_traffic('0, '0, 1'b0, 60, 60);
    endtask

    // Mixed traffic at the reset register values.
    task automatic test_reset_settings();
        run_traffic(MAX_BYTES_RST, MARK_THR_RST, 1'b0, 50, 200);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_ce_marking();
        test_byte_capacity();
        test_priority_order();
        test_fifo_full();
        test_priority_mix();
        test_drain();
        test_byte_limit();
        test_zero_capacity();
        test_reset_settings();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no prediction waiting");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, status);
                check_field("out_tag", want.tag, out_tag);
                check_field("out_bytes", want.bytes, out_bytes);
                check_field("ecn_ce", want.ecn_ce, ecn_ce);
                check_field("serving_class", want.serving_class, serving_class);
                check_field("total_bytes", want.total_bytes, total_bytes);
                check_field("peak_bytes", want.peak_bytes, peak_bytes);
                check_field("drop_count", want.drop_count, drop_count);
            end
        end
    end

    // Ends the run when no transfer has happened on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
